// File: src/thrust_to_pwm_curve_defines.svh
// ---------------------------------------------------------------------------
// thrust_to_pwm_curve assertion macros
// Shorthand for clocked concurrent checks used by the bound checker.
// ---------------------------------------------------------------------------
`ifndef THRUST_TO_PWM_CURVE_DEFINES_SVH
`define THRUST_TO_PWM_CURVE_DEFINES_SVH

// check that is off while reset is high
`define TPC_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define TPC_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tpc_pkg.sv
// ---------------------------------------------------------------------------
// tpc_pkg
// Widths, curve coefficients and shared types of the thrust-to-PWM pipeline.
// ---------------------------------------------------------------------------
package tpc_pkg;

   localparam int FORCE_FRAC_BITS_DEF = 8;
   localparam int PWM_BITS_DEF        = 12;

   localparam int X_W       = 16;            // force command width
   localparam int ACC_W     = 49;            // saturated Horner accumulator
   localparam int PROD_W    = ACC_W + X_W;   // full product width
   localparam int COEF_FRAC = 32;            // coefficient fraction bits
   localparam int WID_W     = ACC_W - COEF_FRAC + 1; // signed integer width
   localparam int HORNER_STEPS = 6;
   localparam int PIPE_DEPTH   = 2 * HORNER_STEPS + 2;

   localparam int PWM_MIN_RESET = 1100;
   localparam int PWM_MAX_RESET = 1900;

   // register indexes
   localparam logic CSR_PWM_MIN = 1'b0;
   localparam logic CSR_PWM_MAX = 1'b1;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [X_W-1:0]   force_type;

   localparam acc_type ACC_MAX = 49'sd281474976710655; // 2^48 - 1

   // Q.32 coefficients, highest degree first
   localparam acc_type CURVE_NEG [HORNER_STEPS+1] = '{
      49'sd12657,
      49'sd1218359,
      49'sd45597128,
      49'sd858569071,
      49'sd9348783956,
      49'sd113258188009,
      49'sd6295828630906
   };
   localparam acc_type CURVE_POS [HORNER_STEPS+1] = '{
      -49'sd2854,
      49'sd353887,
      -49'sd16903428,
      49'sd403741553,
      -49'sd5633504877,
      49'sd89126872608,
      49'sd6591396718621
   };

   // payload carried between Horner stages
   typedef struct packed {
      acc_type   acc;
      force_type x;
      logic      neg;   // curve for forces at or below zero
   } horner_type;

endpackage

// File: src/tpc_horner_step.sv
// ---------------------------------------------------------------------------
// tpc_horner_step
// One Horner step: registered multiply, then floor shift, add and saturate.
// ---------------------------------------------------------------------------
module tpc_horner_step #(
   parameter int STEP            = 1,
   parameter int FORCE_FRAC_BITS = tpc_pkg::FORCE_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tpc_pkg::horner_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output tpc_pkg::horner_type out_data
);

   localparam int PW = tpc_pkg::PROD_W;
   localparam tpc_pkg::acc_type C_NEG = tpc_pkg::CURVE_NEG[STEP];
   localparam tpc_pkg::acc_type C_POS = tpc_pkg::CURVE_POS[STEP];
   localparam logic signed [PW-1:0] LIM = PW'(tpc_pkg::ACC_MAX);

   logic                    m_valid_ff, a_valid_ff;
   logic                    m_ready, a_ready;
   logic signed [PW-1:0]    prod_in, prod_ff;
   tpc_pkg::horner_type     m_data_ff, a_data_ff, a_data_in;
   logic signed [PW-1:0]    shifted, sum;
   tpc_pkg::acc_type        coef;

   assign a_ready  = !a_valid_ff || out_ready;
   assign m_ready  = !m_valid_ff || a_ready;
   assign in_ready = m_ready;

   // 49 x 16 signed product
   assign prod_in = PW'(in_data.acc) * PW'(in_data.x);

   // arithmetic shift gives floor
   assign shifted = prod_ff >>> FORCE_FRAC_BITS;
   assign coef    = m_data_ff.neg ? C_NEG : C_POS;
   assign sum     = shifted + PW'(coef);

   always_comb begin
      a_data_in = m_data_ff;
      if (sum > LIM) begin
         a_data_in.acc = tpc_pkg::ACC_MAX;
      end else if (sum < -LIM) begin
         a_data_in.acc = -tpc_pkg::ACC_MAX;
      end else begin
         a_data_in.acc = sum[tpc_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= in_valid;
         if (a_ready) a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && in_valid) begin
         prod_ff   <= prod_in;
         m_data_ff <= in_data;
      end
      if (a_ready && m_valid_ff) begin
         a_data_ff <= a_data_in;
      end
   end

   assign out_valid = a_valid_ff;
   assign out_data  = a_data_ff;

endmodule

// File: src/tpc_clamp.sv
// ---------------------------------------------------------------------------
// tpc_clamp
// Truncates the Q.32 result toward zero, then clamps to the PWM limits.
// ---------------------------------------------------------------------------
module tpc_clamp #(
   parameter int PWM_BITS = tpc_pkg::PWM_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tpc_pkg::horner_type in_data,
   input  logic [PWM_BITS-1:0] pwm_min,
   input  logic [PWM_BITS-1:0] pwm_max,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [PWM_BITS-1:0] pulse_width,
   output logic                clamped
);

   localparam int AW = tpc_pkg::ACC_W;
   localparam int WW = tpc_pkg::WID_W;
   localparam int CF = tpc_pkg::COEF_FRAC;

   logic                 t_valid_ff, c_valid_ff;
   logic                 t_ready, c_ready;
   tpc_pkg::acc_type     neg_acc;
   logic [AW-CF-1:0]     mag;
   logic signed [WW-1:0] width_in, width_ff;
   logic signed [WW-1:0] min_s, max_s;
   logic [PWM_BITS-1:0]  pulse_in, pulse_ff;
   logic                 clamped_in, clamped_ff;

   assign c_ready  = !c_valid_ff || out_ready;
   assign t_ready  = !t_valid_ff || c_ready;
   assign in_ready = t_ready;

   // truncate toward zero: shift the magnitude, restore the sign
   assign neg_acc  = -in_data.acc;
   assign mag      = in_data.acc[AW-1] ? neg_acc[AW-1:CF] : in_data.acc[AW-1:CF];
   assign width_in = in_data.acc[AW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   assign min_s = $signed(WW'(pwm_min));
   assign max_s = $signed(WW'(pwm_max));

   // the upper-limit check comes first: when the limits cross, a width above pwm_max gives pwm_max, any other pwm_min
   always_comb begin
      if (width_ff > max_s) begin
         pulse_in   = pwm_max;
         clamped_in = 1'b1;
      end else if (width_ff < min_s) begin
         pulse_in   = pwm_min;
         clamped_in = 1'b1;
      end else begin
         pulse_in   = width_ff[PWM_BITS-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (t_ready) t_valid_ff <= in_valid;
         if (c_ready) c_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (t_ready && in_valid) width_ff <= width_in;
      if (c_ready && t_valid_ff) begin
         pulse_ff   <= pulse_in;
         clamped_ff <= clamped_in;
      end
   end

   assign out_valid   = c_valid_ff;
   assign pulse_width = pulse_ff;
   assign clamped     = clamped_ff;

endmodule

// File: src/thrust_to_pwm_curve.sv
// ---------------------------------------------------------------------------
// thrust_to_pwm_curve
// Maps a Q7.8 thrust command to a clamped PWM pulse width through one of
// two sixth-degree polynomials, evaluated by a pipelined Horner chain.
// ---------------------------------------------------------------------------
//
//  channel  direction  payload                          transfer when
//  req_     in         tdata: force_req                 req_tvalid & req_tready
//  rsp_     out        tdata: pulse_width, tuser: clamp rsp_tvalid & rsp_tready
//  csr_     in         index + wdata (pwm_min, pwm_max) csr_we
//
//  One transfer per cycle in and out while rsp_ is not stalled; six Horner
//  steps of two stages each (49x16 multiply, then shift/add/saturate),
//  then a truncate stage and a clamp/output stage.
//  Synchronous reset clears all stage valid bits and loads the default
//  limits (1100 and 1900 us).
//  Each stage holds while its successor is full, so a stall on rsp_ backs
//  up stage by stage; empty stages still fill, and nothing is dropped.
//
module thrust_to_pwm_curve #(
   parameter int FORCE_FRAC_BITS = tpc_pkg::FORCE_FRAC_BITS_DEF,
   parameter int PWM_BITS        = tpc_pkg::PWM_BITS_DEF,
   localparam int RSP_TD_W       = ((PWM_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // input stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] force_req
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_TD_W-1:0] rsp_tdata,   // [PWM_BITS-1:0] pulse_width, rest zero
   output logic                rsp_tuser,   // [0] clamped
   // configuration writes
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [PWM_BITS-1:0] csr_wdata
);

   localparam int NS = tpc_pkg::HORNER_STEPS;

   logic [PWM_BITS-1:0] pwm_min_ff, pwm_max_ff;
   logic [PWM_BITS-1:0] pulse_width;

   // stage k feeds Horner step k+1; entry 0 is the input
   tpc_pkg::horner_type h_data  [NS+1];
   logic                h_valid [NS+1];
   logic                h_ready [NS+1];

   tpc_pkg::force_type  x;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_min_ff <= PWM_BITS'(tpc_pkg::PWM_MIN_RESET);
         pwm_max_ff <= PWM_BITS'(tpc_pkg::PWM_MAX_RESET);
      end else if (csr_we) begin
         unique case (csr_addr)
            tpc_pkg::CSR_PWM_MIN: pwm_min_ff <= csr_wdata;
            tpc_pkg::CSR_PWM_MAX: pwm_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- chain entry: pick curve, seed with the top coefficient ----
   assign x          = $signed(req_tdata);
   assign h_valid[0] = req_tvalid;
   assign req_tready = h_ready[0];

   always_comb begin
      h_data[0].x   = x;
      h_data[0].neg = x[15] || (x == '0);  // zero force takes the negative curve
      h_data[0].acc = h_data[0].neg ? tpc_pkg::CURVE_NEG[0] : tpc_pkg::CURVE_POS[0];
   end

   // ---- Horner steps ----
   for (genvar k = 1; k <= NS; k++) begin : g_step
      tpc_horner_step #(
         .STEP            (k),
         .FORCE_FRAC_BITS (FORCE_FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_valid[k-1]),
         .in_ready  (h_ready[k-1]),
         .in_data   (h_data[k-1]),
         .out_valid (h_valid[k]),
         .out_ready (h_ready[k]),
         .out_data  (h_data[k])
      );
   end

   // ---- truncate, clamp and output register ----
   tpc_clamp #(
      .PWM_BITS (PWM_BITS)
   ) u_clamp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (h_valid[NS]),
      .in_ready    (h_ready[NS]),
      .in_data     (h_data[NS]),
      .pwm_min     (pwm_min_ff),
      .pwm_max     (pwm_max_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .pulse_width (pulse_width),
      .clamped     (rsp_tuser)
   );

   assign rsp_tdata = RSP_TD_W'(pulse_width);

endmodule

// File: src/tpc_checker.sv
// ---------------------------------------------------------------------------
// tpc_checker
// Port-level checks on occupancy and output handshake, bound to the top.
// ---------------------------------------------------------------------------
`include "thrust_to_pwm_curve_defines.svh"

module tpc_checker #(
   parameter int PWM_BITS = tpc_pkg::PWM_BITS_DEF,
   localparam int RSP_TD_W = ((PWM_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_TD_W-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   localparam int DEPTH = tpc_pkg::PIPE_DEPTH;
   localparam int CW    = $clog2(DEPTH + 1);

   logic          req_xfer, rsp_xfer;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // items in flight
   always_comb begin
      case ({req_xfer, rsp_xfer})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   `TPC_CHECK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `TPC_CHECK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `TPC_CHECK(a_no_phantom, clock, reset, rsp_tvalid |-> cnt_ff != '0, "result with nothing in flight")
   `TPC_CHECK(a_full_stalls, clock, reset, (cnt_ff == CW'(DEPTH)) && !rsp_tready |-> !req_tready, "full pipeline took a transfer")

endmodule

bind thrust_to_pwm_curve tpc_checker #(
   .PWM_BITS (PWM_BITS)
) u_tpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
